@@ rtl/core/sbl_pkg.sv @@
// Shared constants and types for the 3x3 Sobel gradient block.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package sbl_pkg;

  // Default frame limits, handed to the top-level parameters.
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Fixed field widths of the streams.
  localparam int PIXEL_W = 8;
  localparam int GRAD_W  = 11;

  // Configuration register widths and reset values.
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int FW_RESET   = 640;
  localparam int FH_RESET   = 480;

  // Smallest frame dimension that still has an interior window.
  localparam int DIM_MIN = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT
  } cfg_reg_t;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic signed [GRAD_W-1:0] grad_t;

endpackage

`default_nettype wire

@@ rtl/core/sbl_pixel_if.sv @@
// Pixel input channel: valid/ready handshake with one grey pixel per request.
// Depends on sbl_pkg for the pixel type.
`timescale 1ns / 1ps
`default_nettype none

interface sbl_pixel_if;
  logic            valid;
  logic            ready;
  sbl_pkg::pixel_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sbl_result_if.sv @@
// Result output channel: valid/ready handshake carrying gradients and position.
// Depends on sbl_pkg for the gradient type.
`timescale 1ns / 1ps
`default_nettype none

interface sbl_result_if #(
  parameter int COL_W = 10,
  parameter int ROW_W = 12
);
  logic             valid;
  logic             ready;
  logic             result_valid;
  sbl_pkg::grad_t   grad_x;
  sbl_pkg::grad_t   grad_y;
  logic [COL_W-1:0] centre_col;
  logic [ROW_W-1:0] centre_row;
  logic             frame_end;

  modport source (output valid, output result_valid, output grad_x, output grad_y,
                  output centre_col, output centre_row, output frame_end,
                  input ready);
  modport sink   (input valid, input result_valid, input grad_x, input grad_y,
                  input centre_col, input centre_row, input frame_end,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/sbl_cfg.sv @@
// Frame size registers with clamping of the values in use to the legal range.
// Depends on sbl_pkg for register widths, indexes and reset values.
`timescale 1ns / 1ps
`default_nettype none

module sbl_cfg #(
  parameter int MAX_WIDTH  = sbl_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sbl_pkg::MAX_HEIGHT_DEF,
  localparam int WEFF_W = $clog2(MAX_WIDTH) + 1,
  localparam int HEFF_W = $clog2(MAX_HEIGHT) + 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sbl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbl_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [WEFF_W-1:0]              width_eff,
  output logic [HEFF_W-1:0]              height_eff
);
  import sbl_pkg::*;

  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_W'(FW_RESET);
      frame_height <= FH_W'(FH_RESET);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Values below the minimum act as the minimum, values above the limit as the limit.
  always_comb begin
    if (32'(frame_width) < 32'(DIM_MIN)) begin
      width_eff = WEFF_W'(DIM_MIN);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      width_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      width_eff = WEFF_W'(frame_width);
    end

    if (32'(frame_height) < 32'(DIM_MIN)) begin
      height_eff = HEFF_W'(DIM_MIN);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      height_eff = HEFF_W'(MAX_HEIGHT);
    end else begin
      height_eff = HEFF_W'(frame_height);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sbl_linebuf.sv @@
// Two row buffers in one module: one read and one write port each, registered reads.
// Depends on sbl_pkg for the pixel type.
`timescale 1ns / 1ps
`default_nettype none

module sbl_linebuf #(
  parameter int DEPTH = sbl_pkg::MAX_WIDTH_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output sbl_pkg::pixel_t rd_older,
  output sbl_pkg::pixel_t rd_newer,
  input  logic            wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  sbl_pkg::pixel_t wr_older,
  input  sbl_pkg::pixel_t wr_newer
);
  import sbl_pkg::*;

  pixel_t older_mem [DEPTH];
  pixel_t newer_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_older <= older_mem[rd_addr];
      rd_newer <= newer_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      older_mem[wr_addr] <= wr_older;
      newer_mem[wr_addr] <= wr_newer;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sbl_grad.sv @@
// 3x3 window registers and the Sobel kernels applied to the current window.
// Depends on sbl_pkg for the pixel and gradient types.
`timescale 1ns / 1ps
`default_nettype none

module sbl_grad (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift_en,
  input  sbl_pkg::pixel_t col_top,
  input  sbl_pkg::pixel_t col_mid,
  input  sbl_pkg::pixel_t col_bot,
  output sbl_pkg::grad_t  grad_x,
  output sbl_pkg::grad_t  grad_y
);
  import sbl_pkg::*;

  // win[row][col]; column 2 is the newest.
  pixel_t win [3][3];

  logic [PIXEL_W+1:0] pos_x;
  logic [PIXEL_W+1:0] neg_x;
  logic [PIXEL_W+1:0] pos_y;
  logic [PIXEL_W+1:0] neg_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (shift_en) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= col_top;
      win[1][2] <= col_mid;
      win[2][2] <= col_bot;
    end
  end

  // Each side of a kernel sums to at most 1020, so the difference fits in 11 bits.
  always_comb begin
    pos_x = {2'b00, win[0][2]} + {1'b0, win[1][2], 1'b0} + {2'b00, win[2][2]};
    neg_x = {2'b00, win[0][0]} + {1'b0, win[1][0], 1'b0} + {2'b00, win[2][0]};
    pos_y = {2'b00, win[2][0]} + {1'b0, win[2][1], 1'b0} + {2'b00, win[2][2]};
    neg_y = {2'b00, win[0][0]} + {1'b0, win[0][1], 1'b0} + {2'b00, win[0][2]};
    grad_x = $signed({1'b0, pos_x} - {1'b0, neg_x});
    grad_y = $signed({1'b0, pos_y} - {1'b0, neg_y});
  end

endmodule

`default_nettype wire

@@ rtl/core/sobel_gradient_3x3.sv @@
// Streaming 3x3 Sobel gradient top level: counters, pipeline control and result register.
// Depends on sbl_pkg, sbl_pixel_if, sbl_result_if, sbl_cfg, sbl_linebuf and sbl_grad.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one grey pixel per request in raster order and returns exactly one
// result request for every pixel, one pixel per clock when both sides keep up. The
// path is three registered steps: the row buffers' registered read port, the window
// shift, and the gradient adders feeding the output register; a stall on the output
// lets the earlier steps fill up, and the input stops only when every step is full. A
// result with result_valid set carries the horizontal and vertical gradients of the
// window centre, which is one column left of and one row above the pixel just taken;
// border positions come back with result_valid low and all of gradients and
// coordinates zero, so the consumer zero-fills them. frame_end marks the result of the
// last pixel of each frame. The frame width and height registers are written through
// the configuration port; the user must write them only while the block is idle, which
// the block itself does not enforce. Values below three act as three and values above
// the limits act as the limits. The row buffers are not cleared after reset: entries
// never written only reach border windows, so there is no clearing pass and the block
// is ready as soon as reset drops.
module sobel_gradient_3x3 #(
  parameter int MAX_WIDTH  = sbl_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sbl_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sbl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbl_pkg::CFG_DATA_W-1:0] cfg_data,
  sbl_pixel_if.sink                      pixels,
  sbl_result_if.source                   results
);
  import sbl_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // Frame size in use.
  logic [COL_W:0] width_eff;
  logic [ROW_W:0] height_eff;

  // Position of the next pixel.
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count_next;
  logic [ROW_W-1:0] row_count_next;

  // Position of the pixel on the input, after any wrap caused by a smaller frame size.
  logic             col_wrap;
  logic [ROW_W:0]   row_pre;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic             cur_last;
  logic             cur_interior;
  logic             row_end;

  // Step one: pixel and position, waiting for the row buffer read.
  logic             s1_v;
  pixel_t           s1_pix;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;
  logic             s1_last;
  logic             s1_interior;
  pixel_t           rd_older;
  pixel_t           rd_newer;

  // Step two: window holds this pixel's neighborhood.
  logic             s2_v;
  logic [COL_W-1:0] s2_col;
  logic [ROW_W-1:0] s2_row;
  logic             s2_last;
  logic             s2_interior;
  grad_t            win_gx;
  grad_t            win_gy;

  // Output register.
  logic             out_v;

  logic in_fire;
  logic s1_adv;
  logic s2_adv;
  logic out_free;
  logic s2_free;
  logic s1_free;

  sbl_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .width_eff  (width_eff),
    .height_eff (height_eff)
  );

  // Each step moves on when the one after it is empty or moving on too.
  always_comb begin
    out_free = !out_v || results.ready;
    s2_adv   = s2_v && out_free;
    s2_free  = !s2_v || out_free;
    s1_adv   = s1_v && s2_free;
    s1_free  = !s1_v || s2_free;
    in_fire  = pixels.valid && s1_free;
  end

  assign pixels.ready = s1_free;

  // A frame size lowered between frames can leave the counters past the new edge;
  // the position then wraps to the next row, and past the last row to row zero.
  always_comb begin
    col_wrap = {1'b0, col_count} >= width_eff;
    row_pre  = col_wrap ? ({1'b0, row_count} + 1'b1) : {1'b0, row_count};
    cur_col  = col_wrap ? '0 : col_count;
    cur_row  = (row_pre >= height_eff) ? '0 : row_pre[ROW_W-1:0];

    cur_last     = ({1'b0, cur_col} == width_eff - 1'b1) &&
                   ({1'b0, cur_row} == height_eff - 1'b1);
    row_end      = ({1'b0, cur_col} + 1'b1) >= width_eff;
    cur_interior = (cur_col >= COL_W'(2)) && (cur_row >= ROW_W'(2));

    if (cur_last) begin
      col_count_next = '0;
      row_count_next = '0;
    end else if (row_end) begin
      col_count_next = '0;
      row_count_next = cur_row + 1'b1;
    end else begin
      col_count_next = cur_col + 1'b1;
      row_count_next = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_fire) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // The read for a column is issued as its pixel is taken and the write-back happens
  // one step later, so a read never meets a pending write to the same column.
  sbl_linebuf #(
    .DEPTH (MAX_WIDTH)
  ) u_linebuf (
    .clk      (clk),
    .rd_en    (in_fire),
    .rd_addr  (cur_col),
    .rd_older (rd_older),
    .rd_newer (rd_newer),
    .wr_en    (s1_adv),
    .wr_addr  (s1_col),
    .wr_older (rd_newer),
    .wr_newer (s1_pix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_free) begin
      s1_v <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix      <= pixels.pixel;
      s1_col      <= cur_col;
      s1_row      <= cur_row;
      s1_last     <= cur_last;
      s1_interior <= cur_interior;
    end
  end

  sbl_grad u_grad (
    .clk      (clk),
    .rst      (rst),
    .shift_en (s1_adv),
    .col_top  (rd_older),
    .col_mid  (rd_newer),
    .col_bot  (s1_pix),
    .grad_x   (win_gx),
    .grad_y   (win_gy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_free) begin
      s2_v <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_col      <= s1_col;
      s2_row      <= s1_row;
      s2_last     <= s1_last;
      s2_interior <= s1_interior;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_free) begin
      out_v <= s2_adv;
    end
  end

  // Border results carry zero in every field but frame_end.
  always_ff @(posedge clk) begin
    if (s2_adv) begin
      results.result_valid <= s2_interior;
      results.grad_x       <= s2_interior ? win_gx : '0;
      results.grad_y       <= s2_interior ? win_gy : '0;
      results.centre_col   <= s2_interior ? (s2_col - 1'b1) : '0;
      results.centre_row   <= s2_interior ? (s2_row - 1'b1) : '0;
      results.frame_end    <= s2_last;
    end
  end

  assign results.valid = out_v;

endmodule

`default_nettype wire

@@ rtl/core/sbl_checker.sv @@
// Port-level checks of the Sobel gradient top level, attached by the bind at the end.
// Depends on sbl_pkg for the gradient width; binds into sobel_gradient_3x3.
`timescale 1ns / 1ps
`default_nettype none

module sbl_checker #(
  parameter int MAX_WIDTH  = sbl_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sbl_pkg::MAX_HEIGHT_DEF,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic                         result_valid,
  input logic [sbl_pkg::GRAD_W-1:0]   grad_x,
  input logic [sbl_pkg::GRAD_W-1:0]   grad_y,
  input logic [COL_W-1:0]             centre_col,
  input logic [ROW_W-1:0]             centre_row,
  input logic                         frame_end
);
  import sbl_pkg::*;

  // A result waiting for the consumer keeps every field.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(result_valid) &&
      $stable(grad_x) && $stable(grad_y) && $stable(centre_col) &&
      $stable(centre_row) && $stable(frame_end))
    else $error("result changed while stalled");

  // Nothing is offered in the cycle right after reset.
  a_reset: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result offered straight after reset");

  // Border results carry only zeros besides frame_end.
  a_border_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !result_valid |->
      grad_x == '0 && grad_y == '0 && centre_col == '0 && centre_row == '0)
    else $error("border result with nonzero fields");

  // Interior results lie inside the frame border and in the kernel range.
  a_interior: assert property (@(posedge clk) disable iff (rst)
    res_valid && result_valid |->
      centre_col != '0 && centre_row != '0 &&
      $signed(grad_x) >= -11'sd1020 && $signed(grad_x) <= 11'sd1020 &&
      $signed(grad_y) >= -11'sd1020 && $signed(grad_y) <= 11'sd1020)
    else $error("interior result out of range");

endmodule

bind sobel_gradient_3x3 sbl_checker #(
  .MAX_WIDTH  (MAX_WIDTH),
  .MAX_HEIGHT (MAX_HEIGHT)
) u_sbl_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (results.valid),
  .res_ready    (results.ready),
  .result_valid (results.result_valid),
  .grad_x       (results.grad_x),
  .grad_y       (results.grad_y),
  .centre_col   (results.centre_col),
  .centre_row   (results.centre_row),
  .frame_end    (results.frame_end)
);

`default_nettype wire
